@@ design/kte_pkg.sv @@
// kte_pkg.sv: shared types, constants and helpers of the keyed text field number extractor
`timescale 1ns / 1ps

package kte_pkg;

    // number of fields after the key and kept fraction digits
    localparam int NUM_FIELDS  = 5;
    localparam int FRAC_DIGITS = 3;

    localparam int FIELD_W = 3;
    localparam int FRAC_W  = 2;
    localparam int MAG_W   = 32;

    localparam logic [FIELD_W-1:0] LAST_FIELD_IDX = FIELD_W'(NUM_FIELDS - 1);
    localparam logic [FRAC_W-1:0]  FRAC_KEEP      = FRAC_W'(FRAC_DIGITS);

    // magnitude cap, 2^31
    localparam logic [MAG_W-1:0] MAG_CAP = 32'h8000_0000;

    // parse phases
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_FIELDS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    // number phases
    localparam logic [1:0] NP_BEFORE = 2'd0;
    localparam logic [1:0] NP_INT    = 2'd1;
    localparam logic [1:0] NP_FRAC   = 2'd2;
    localparam logic [1:0] NP_ENDED  = 2'd3;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       message_start;
    } kte_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_number;
        logic signed [31:0] field_value;
        logic               value_overflow;
        logic               last_field;
    } kte_out_t;

    // power of ten for the missing fraction digits
    function automatic logic [9:0] scale_of(input logic [FRAC_W-1:0] shift);
        logic [9:0] s;
        case (shift)
            2'd0:    s = 10'd1;
            2'd1:    s = 10'd10;
            2'd2:    s = 10'd100;
            default: s = 10'd1000;
        endcase
        return s;
    endfunction

endpackage

@@ design/kte_in_if.sv @@
// kte_in_if.sv: byte channel carrying one reply text byte per transfer
`timescale 1ns / 1ps

interface kte_in_if;
    import kte_pkg::*;

    logic    valid;
    logic    ready;
    kte_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/kte_out_if.sv @@
// kte_out_if.sv: result channel carrying one parsed field per transfer
`timescale 1ns / 1ps

interface kte_out_if;
    import kte_pkg::*;

    logic     valid;
    logic     ready;
    kte_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/keyed_text_field_number_extractor.sv @@
// keyed_text_field_number_extractor.sv: byte-wise parser of keyed numeric fields
`timescale 1ns / 1ps

// Takes a sensor reply one byte per transfer, looks for the key "T" (quote, T,
// quote) and then reads NUM_FIELDS fields. In each field, bytes up to the first
// colon are ignored; after it leading white space is skipped, then an optional
// sign, integer digits, a point and fraction digits form the number. A comma or
// closing brace ends the field and gives one result transfer: the value times
// 10^FRAC_DIGITS (extra fraction digits truncated), saturated to 32 bits signed
// with value_overflow set. A reply without the key gives no results; after the
// last field bytes are ignored until message_start marks a new reply. One byte
// is taken every cycle unless a field-ending byte meets a result not yet taken;
// the result then moves from the input register to the result register. The only
// wide path is 32 x 10 bit constant scaling at field end plus saturation compare.
module keyed_text_field_number_extractor (
    input  logic       clk,
    input  logic       rst_n,
    kte_in_if.sink     byte_ch,
    kte_out_if.source  field_ch
);
    import kte_pkg::*;

    // input register
    logic          s1_valid_reg;
    kte_in_t       s1_data_reg;

    // parser state
    logic [1:0]         parse_phase_reg,  parse_phase_next;
    logic [1:0]         key_match_reg,    key_match_next;
    logic [FIELD_W-1:0] cur_field_reg,    cur_field_next;
    logic               colon_seen_reg,   colon_seen_next;
    logic [1:0]         num_phase_reg,    num_phase_next;
    logic               is_neg_reg,       is_neg_next;
    logic [MAG_W-1:0]   mag_reg,          mag_next;
    logic [FRAC_W-1:0]  frac_cnt_reg,     frac_cnt_next;
    logic               sat_reg,          sat_next;

    // result register
    logic     out_valid_reg;
    kte_out_t out_data_reg;

    // state as seen by this byte, after an optional new-reply clear
    logic [1:0]         ph;
    logic [1:0]         km;
    logic [FIELD_W-1:0] cf;
    logic               cs;
    logic [1:0]         np;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [FRAC_W-1:0]  fc;
    logic               sat;

    logic [7:0]   b;
    logic         is_digit;
    logic         is_space;
    logic         take;
    logic [35:0]  digit_sum;
    logic [MAG_W-1:0] mag_digit;
    logic         digit_sat;

    logic         emit;
    logic [FRAC_W-1:0] shift;
    logic [41:0]  scaled;
    logic [41:0]  limit;
    logic [41:0]  clipped;
    logic         clip;
    logic         is_last;
    kte_out_t     result;

    logic s1_fire;

    assign b        = s1_data_reg.in_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

    // a byte that makes no result never waits on the result side
    assign s1_fire       = s1_valid_reg && (!emit || !out_valid_reg || field_ch.ready);
    assign byte_ch.ready = !s1_valid_reg || s1_fire;

    assign field_ch.valid = out_valid_reg;
    assign field_ch.data  = out_data_reg;

    // new reply clears everything before the byte is looked at
    always_comb
    begin
        if (s1_data_reg.message_start)
        begin
            ph  = PH_SEARCH;
            km  = 2'd0;
            cf  = '0;
            cs  = 1'b0;
            np  = NP_BEFORE;
            neg = 1'b0;
            mag = '0;
            fc  = '0;
            sat = 1'b0;
        end
        else
        begin
            ph  = parse_phase_reg;
            km  = key_match_reg;
            cf  = cur_field_reg;
            cs  = colon_seen_reg;
            np  = num_phase_reg;
            neg = is_neg_reg;
            mag = mag_reg;
            fc  = frac_cnt_reg;
            sat = sat_reg;
        end
    end

    // accumulate one decimal digit, capped at 2^31
    always_comb
    begin
        digit_sum = ({4'd0, mag} * 36'd10) + {32'd0, b[3:0]};
        digit_sat = digit_sum > {4'd0, MAG_CAP};
        mag_digit = digit_sat ? MAG_CAP : digit_sum[MAG_W-1:0];
    end

    // field-end scaling and saturation
    always_comb
    begin
        shift   = FRAC_KEEP - fc;
        scaled  = {10'd0, mag} * {32'd0, scale_of(shift)};
        limit   = neg ? {10'd0, MAG_CAP} : ({10'd0, MAG_CAP} - 42'd1);
        clip    = scaled > limit;
        clipped = clip ? limit : scaled;
        is_last = cf >= LAST_FIELD_IDX;

        result.field_number   = cf;
        result.field_value    = neg ? (32'd0 - clipped[31:0]) : clipped[31:0];
        result.value_overflow = sat || clip;
        result.last_field     = is_last;
    end

    // next parser state
    always_comb
    begin
        parse_phase_next = ph;
        key_match_next   = km;
        cur_field_next   = cf;
        colon_seen_next  = cs;
        num_phase_next   = np;
        is_neg_next      = neg;
        mag_next         = mag;
        frac_cnt_next    = fc;
        sat_next         = sat;
        emit             = 1'b0;
        take             = 1'b0;

        unique case (ph)
            PH_SEARCH:
            begin
                unique case (km)
                    2'd0:
                    begin
                        key_match_next = (b == CH_QUOTE) ? 2'd1 : 2'd0;
                    end
                    2'd1:
                    begin
                        if (b == CH_T)
                            key_match_next = 2'd2;
                        else
                            key_match_next = (b == CH_QUOTE) ? 2'd1 : 2'd0;
                    end
                    default:
                    begin
                        // full key: start reading fields
                        key_match_next = 2'd0;
                        if (b == CH_QUOTE)
                        begin
                            parse_phase_next = PH_FIELDS;
                            cur_field_next   = '0;
                            colon_seen_next  = 1'b0;
                            num_phase_next   = NP_BEFORE;
                            is_neg_next      = 1'b0;
                            mag_next         = '0;
                            frac_cnt_next    = '0;
                            sat_next         = 1'b0;
                        end
                    end
                endcase
            end
            PH_FIELDS:
            begin
                if ((b == CH_COMMA) || (b == CH_RBRACE))
                begin
                    emit            = 1'b1;
                    colon_seen_next = 1'b0;
                    num_phase_next  = NP_BEFORE;
                    is_neg_next     = 1'b0;
                    mag_next        = '0;
                    frac_cnt_next   = '0;
                    sat_next        = 1'b0;
                    if (is_last)
                        parse_phase_next = PH_DONE;
                    else
                        cur_field_next = cf + 1'b1;
                end
                else if (cs)
                begin
                    unique case (np)
                        NP_BEFORE:
                        begin
                            if (is_space)
                                num_phase_next = NP_BEFORE;
                            else if (b == CH_MINUS)
                            begin
                                is_neg_next    = 1'b1;
                                num_phase_next = NP_INT;
                            end
                            else if (b == CH_PLUS)
                                num_phase_next = NP_INT;
                            else if (is_digit)
                            begin
                                take           = 1'b1;
                                num_phase_next = NP_INT;
                            end
                            else if (b == CH_POINT)
                                num_phase_next = NP_FRAC;
                            else
                                num_phase_next = NP_ENDED;
                        end
                        NP_INT:
                        begin
                            if (is_digit)
                                take = 1'b1;
                            else if (b == CH_POINT)
                                num_phase_next = NP_FRAC;
                            else
                                num_phase_next = NP_ENDED;
                        end
                        NP_FRAC:
                        begin
                            if (is_digit)
                            begin
                                // digits past the kept count are dropped
                                if (fc < FRAC_KEEP)
                                begin
                                    take          = 1'b1;
                                    frac_cnt_next = fc + 1'b1;
                                end
                            end
                            else
                                num_phase_next = NP_ENDED;
                        end
                        default:
                        begin
                            num_phase_next = NP_ENDED;
                        end
                    endcase
                end
                else if (b == CH_COLON)
                    colon_seen_next = 1'b1;
            end
            default:
            begin
                // done (and the unused code): ignore bytes
                parse_phase_next = ph;
            end
        endcase

        if (take)
        begin
            mag_next = mag_digit;
            sat_next = sat || digit_sat;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (byte_ch.ready)
            s1_valid_reg <= byte_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
            s1_data_reg <= byte_ch.data;
    end

    // parser state, updated once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg <= PH_SEARCH;
            key_match_reg   <= 2'd0;
            cur_field_reg   <= '0;
            colon_seen_reg  <= 1'b0;
            num_phase_reg   <= NP_BEFORE;
            is_neg_reg      <= 1'b0;
            mag_reg         <= '0;
            frac_cnt_reg    <= '0;
            sat_reg         <= 1'b0;
        end
        else if (s1_fire)
        begin
            parse_phase_reg <= parse_phase_next;
            key_match_reg   <= key_match_next;
            cur_field_reg   <= cur_field_next;
            colon_seen_reg  <= colon_seen_next;
            num_phase_reg   <= num_phase_next;
            is_neg_reg      <= is_neg_next;
            mag_reg         <= mag_next;
            frac_cnt_reg    <= frac_cnt_next;
            sat_reg         <= sat_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && emit)
            out_valid_reg <= 1'b1;
        else if (field_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
            out_data_reg <= result;
    end

`ifndef SYNTHESIS
    // field index never runs past the last field
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_field_reg <= LAST_FIELD_IDX)
        else $error("field index beyond last field");

    // kept fraction digits never exceed the configured count
    assert property (@(posedge clk) disable iff (!rst_n)
        frac_cnt_reg <= FRAC_KEEP)
        else $error("fraction digit count too large");

    // a saturated accumulator holds its cap
    assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |-> (mag_reg == MAG_CAP))
        else $error("saturated accumulator left its cap");

    // a result marked last carries the last field index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.last_field) |->
            (out_data_reg.field_number == LAST_FIELD_IDX))
        else $error("last flag on wrong field");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top.sv: self-checking bench for the keyed text field number extractor
`timescale 1ns / 1ps

module tb_top;
    import kte_pkg::*;

    // white space codes that the package does not name
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // rough number of text bytes to push through the parser
    localparam int TOTAL_BYTES = 1700;

    // tracks the parser state byte by byte and holds the fields still owed
    class field_board;
        logic [1:0]  phase;
        logic [1:0]  key_count;
        logic [2:0]  field_idx;
        logic        colon_hit;
        logic [1:0]  num_phase;
        logic        negative;
        logic [31:0] magnitude;
        logic [1:0]  frac_kept;
        logic        capped;
        kte_out_t    pending_fields[$];
        int          errors;
        int          fields_checked;
        int          overflows_seen;
        int          negatives_seen;
        int          keys_found;

        function new();
            errors         = 0;
            fields_checked = 0;
            overflows_seen = 0;
            negatives_seen = 0;
            keys_found     = 0;
            restart();
        endfunction

        function void clear_number();
            colon_hit = 1'b0;
            num_phase = NP_BEFORE;
            negative  = 1'b0;
            magnitude = '0;
            frac_kept = '0;
            capped    = 1'b0;
        endfunction

        function void restart();
            phase     = PH_SEARCH;
            key_count = '0;
            field_idx = '0;
            clear_number();
        endfunction

        function void take_digit(logic [3:0] d);
            logic [63:0] t;
            t = {32'd0, magnitude} * 64'd10 + 64'(d);
            if (t > 64'(MAG_CAP))
            begin
                capped = 1'b1;
                t      = 64'(MAG_CAP);
            end
            magnitude = t[31:0];
        endfunction

        function void scan_number(logic [7:0] b);
            logic is_digit;
            is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
            case (num_phase)
                NP_BEFORE:
                begin
                    if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                    begin
                        // leading white space is skipped
                    end
                    else if (b == CH_MINUS)
                    begin
                        negative  = 1'b1;
                        num_phase = NP_INT;
                    end
                    else if (b == CH_PLUS)
                        num_phase = NP_INT;
                    else if (is_digit)
                    begin
                        take_digit(4'(b - CH_ZERO));
                        num_phase = NP_INT;
                    end
                    else if (b == CH_POINT)
                        num_phase = NP_FRAC;
                    else
                        num_phase = NP_ENDED;
                end
                NP_INT:
                begin
                    if (is_digit)
                        take_digit(4'(b - CH_ZERO));
                    else if (b == CH_POINT)
                        num_phase = NP_FRAC;
                    else
                        num_phase = NP_ENDED;
                end
                NP_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (frac_kept < FRAC_KEEP)
                        begin
                            take_digit(4'(b - CH_ZERO));
                            frac_kept = frac_kept + 2'd1;
                        end
                    end
                    else
                        num_phase = NP_ENDED;
                end
                default:
                begin
                end
            endcase
        endfunction

        // one accepted text byte; queues a field when it closes one
        function void note_byte(kte_in_t x);
            logic [7:0]  b;
            logic [1:0]  shift;
            logic [63:0] scale;
            logic [63:0] m;
            logic [63:0] lim;
            logic        last;
            kte_out_t    res;
            b = x.in_byte;
            if (x.message_start)
                restart();
            if (phase == PH_SEARCH)
            begin
                case (key_count)
                    2'd0: key_count = (b == CH_QUOTE) ? 2'd1 : 2'd0;
                    2'd1:
                    begin
                        if (b == CH_T)
                            key_count = 2'd2;
                        else
                            key_count = (b == CH_QUOTE) ? 2'd1 : 2'd0;
                    end
                    default:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            phase     = PH_FIELDS;
                            field_idx = '0;
                            clear_number();
                            keys_found++;
                        end
                        key_count = '0;
                    end
                endcase
                return;
            end
            if (phase != PH_FIELDS)
                return;
            if (b == CH_COMMA || b == CH_RBRACE)
            begin
                shift = FRAC_KEEP - frac_kept;
                case (shift)
                    2'd0:    scale = 64'd1;
                    2'd1:    scale = 64'd10;
                    2'd2:    scale = 64'd100;
                    default: scale = 64'd1000;
                endcase
                m    = {32'd0, magnitude} * scale;
                lim  = negative ? 64'(MAG_CAP) : 64'(MAG_CAP) - 64'd1;
                last = (field_idx >= LAST_FIELD_IDX);
                res.value_overflow = capped;
                if (m > lim)
                begin
                    m                  = lim;
                    res.value_overflow = 1'b1;
                end
                res.field_number = field_idx;
                res.field_value  = negative ? (32'd0 - m[31:0]) : m[31:0];
                res.last_field   = last;
                pending_fields.push_back(res);
                clear_number();
                if (last)
                    phase = PH_DONE;
                else
                    field_idx = field_idx + 3'd1;
                return;
            end
            if (colon_hit)
                scan_number(b);
            else if (b == CH_COLON)
                colon_hit = 1'b1;
        endfunction

        // one accepted result against the oldest owed field
        function void check_field(kte_out_t got);
            kte_out_t want;
            if (pending_fields.size() == 0)
            begin
                $display("%0t: unexpected field %0d value %0d", $time,
                         got.field_number, got.field_value);
                errors++;
                return;
            end
            want = pending_fields.pop_front();
            fields_checked++;
            if (want.value_overflow)
                overflows_seen++;
            if (want.field_value < 0)
                negatives_seen++;
            if (got.field_number !== want.field_number)
            begin
                $display("%0t: field_number expected %0d, got %0d", $time,
                         want.field_number, got.field_number);
                errors++;
            end
            if (got.field_value !== want.field_value)
            begin
                $display("%0t: field_value expected %0d, got %0d", $time,
                         want.field_value, got.field_value);
                errors++;
            end
            if (got.value_overflow !== want.value_overflow)
            begin
                $display("%0t: value_overflow expected %0b, got %0b", $time,
                         want.value_overflow, got.value_overflow);
                errors++;
            end
            if (got.last_field !== want.last_field)
            begin
                $display("%0t: last_field expected %0b, got %0b", $time,
                         want.last_field, got.last_field);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    kte_in_if  byte_ch ();
    kte_out_if field_ch ();

    keyed_text_field_number_extractor u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .field_ch (field_ch)
    );

    field_board board = new();

    // text staged for the next reply and the message_start flag for its next byte
    kte_in_t reply_text[$];
    logic    start_pending;

    // knobs for the sender and the receiver
    logic tx_idle_en    = 1'b0;
    logic rx_idle_en    = 1'b0;
    int   rx_hold_cycles = 0;

    int bytes_sent   = 0;
    int replies_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous ceiling on the whole run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d fields still owed", board.pending_fields.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // every transfer into the parser updates the expected fields
    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
            board.note_byte(byte_ch.data);
    end

    // every result transfer is checked against the oldest owed field
    always @(posedge clk)
    begin
        if (rst_n && field_ch.valid && field_ch.ready)
            board.check_field(field_ch.data);
    end

    // result side: a long hold-off on request, else random stall bursts when enabled
    initial
    begin
        int gap_left;
        gap_left       = 0;
        field_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                field_ch.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (gap_left > 0)
            begin
                field_ch.ready <= 1'b0;
                gap_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 9) == 0)
            begin
                field_ch.ready <= 1'b0;
                gap_left = $urandom_range(1, 19) - 1;
            end
            else
                field_ch.ready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // stage one byte; the first byte after a new reply carries message_start
    task automatic push_ch(input logic [7:0] c);
        kte_in_t x;
        x.in_byte       = c;
        x.message_start = start_pending;
        start_pending   = 1'b0;
        reply_text.push_back(x);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_ch(s[i]);
    endtask

    // offer one byte and hold it until the parser takes it; the valid stays
    // high into the next byte unless an idle burst follows
    task automatic send_byte(input kte_in_t x);
        byte_ch.valid <= 1'b1;
        byte_ch.data  <= x;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
        if (tx_idle_en && $urandom_range(0, 7) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_text();
        foreach (reply_text[i])
            send_byte(reply_text[i]);
        reply_text.delete();
    endtask

    // stop sending and let every owed field come out
    task automatic wait_drain();
        byte_ch.valid <= 1'b0;
        while (board.pending_fields.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // one random reply: mostly well-formed text with random numbers, some
    // with a broken or missing key, some cut short, some pure byte noise
    task automatic send_reply();
        int shape;
        int fields;
        int pick;
        int digits;
        int keep;
        shape = $urandom_range(0, 19);
        // continuation shape: no message_start, so the old state carries on
        start_pending = (shape != 3);
        if (shape == 0)
        begin
            // raw noise over the full byte range, message_start at random
            repeat ($urandom_range(8, 30))
            begin
                start_pending = ($urandom_range(0, 7) == 0);
                push_ch(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            // junk ahead of the key, partial keys among it
            repeat ($urandom_range(0, 3))
            begin
                case ($urandom_range(0, 2))
                    0:       push_ch(CH_QUOTE);
                    1:       push_ch(CH_T);
                    default: push_ch(8'($urandom_range(8'h20, 8'h7E)));
                endcase
            end
            if (shape == 1)
            begin
                // key that never completes
                case ($urandom_range(0, 2))
                    0:       push_str("\"t\"");
                    1:       push_str("\"T'");
                    default: push_str("T\"");
                endcase
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    push_ch(CH_QUOTE);
                push_ch(CH_QUOTE);
                push_ch(CH_T);
                push_ch(CH_QUOTE);
            end
            push_str(":{");
            fields = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NUM_FIELDS + 2)
                                                 : NUM_FIELDS;
            for (int i = 0; i < fields; i++)
            begin
                // quoted name, sometimes missing
                if ($urandom_range(0, 7) != 0)
                begin
                    push_ch(CH_QUOTE);
                    repeat ($urandom_range(1, 4))
                        push_ch(8'h61 + 8'($urandom_range(0, 25)));
                    push_ch(CH_QUOTE);
                end
                // a field without its colon reads as empty
                if ($urandom_range(0, 11) != 0)
                    push_ch(CH_COLON);
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        case ($urandom_range(0, 5))
                            0:       push_ch(CH_SPACE);
                            1:       push_ch(CH_TAB);
                            2:       push_ch(CH_LF);
                            3:       push_ch(CH_VT);
                            4:       push_ch(CH_FF);
                            default: push_ch(CH_CR);
                        endcase
                    end
                end
                // sign, sometimes doubled
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    push_ch(CH_MINUS);
                else if (pick < 5)
                    push_ch(CH_PLUS);
                else if (pick == 5)
                begin
                    push_ch(CH_PLUS);
                    push_ch(CH_MINUS);
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    // right at the signed 32-bit limit once scaled
                    push_str("2147483");
                    case ($urandom_range(0, 3))
                        0:       push_str(".647");
                        1:       push_str(".648");
                        2:       push_str(".6489");
                        default: push_str("4");
                    endcase
                end
                else
                begin
                    // mostly short numbers, a few long enough to saturate
                    pick   = $urandom_range(0, 19);
                    digits = (pick < 12) ? $urandom_range(0, 4)
                           : (pick < 17) ? $urandom_range(5, 8) : $urandom_range(9, 13);
                    repeat (digits)
                        push_ch(rand_digit());
                    if ($urandom_range(0, 1) == 1)
                    begin
                        push_ch(CH_POINT);
                        repeat ($urandom_range(0, 5))
                            push_ch(rand_digit());
                    end
                end
                // tails that end the number early
                if ($urandom_range(0, 5) == 0)
                begin
                    case ($urandom_range(0, 7))
                        0:       push_str("e3");
                        1:       push_str("E-2");
                        2:       push_str("x1F");
                        3:       push_str("inf");
                        4:       push_str("nan");
                        5:       push_str(":7");
                        6:       push_str("-4");
                        default: push_str(" 5");
                    endcase
                end
                if (i == fields - 1 || $urandom_range(0, 29) == 0)
                    push_ch(CH_RBRACE);
                else
                    push_ch(CH_COMMA);
            end
            // bytes after the reply, ignored once all fields are in
            repeat ($urandom_range(0, 2))
                push_ch(8'($urandom_range(8'h20, 8'h7E)));
            if (shape == 2)
            begin
                // reply cut short; the next message_start must recover
                keep = $urandom_range(1, reply_text.size());
                while (reply_text.size() > keep)
                    void'(reply_text.pop_back());
            end
        end
        replies_sent++;
        send_text();
    endtask

    initial
    begin
        int waited;
        rst_n         = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data  = '0;
        start_pending = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: negative zero, empty field, white space with sign and
        // extra fraction digits, positive overflow, exact negative limit,
        // bytes after the last field
        start_pending = 1'b1;
        push_str("x\"T\":-0,");
        push_ch(CH_COMMA);
        push_ch(CH_COLON);
        push_ch(CH_SPACE);
        push_ch(CH_TAB);
        push_str("+1.23456,:2147484,:-2147483.648}9,");
        send_text();
        // reply whose key never matches
        start_pending = 1'b1;
        push_str("\"t\":5,");
        send_text();
        // exponent, second sign, bare point, the remaining white space codes, saturation
        start_pending = 1'b1;
        push_str("\"T\":1e5,:+-3,:.9999,:");
        push_ch(CH_VT);
        push_ch(CH_FF);
        push_ch(CH_CR);
        push_ch(CH_LF);
        push_str("12,:-99999999999}");
        send_text();
        replies_sent += 3;
        wait_drain();

        // random replies with idling on both sides
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (bytes_sent < TOTAL_BYTES * 3 / 10)
            send_reply();

        // long result hold-off while bytes keep coming, so the parser backs up
        tx_idle_en     = 1'b0;
        rx_hold_cycles = 400;
        repeat (5)
            send_reply();
        wait_drain();

        // a stretch with no idling at all
        rx_idle_en = 1'b0;
        while (bytes_sent < TOTAL_BYTES * 5 / 10)
            send_reply();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (bytes_sent < TOTAL_BYTES * 8 / 10)
            send_reply();

        // closing part runs at full rate
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (bytes_sent < TOTAL_BYTES)
            send_reply();
        byte_ch.valid <= 1'b0;

        waited = 0;
        while (board.pending_fields.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (board.pending_fields.size() != 0)
        begin
            $display("%0t: %0d expected fields never arrived, next field %0d value %0d",
                     $time, board.pending_fields.size(),
                     board.pending_fields[0].field_number,
                     board.pending_fields[0].field_value);
            board.errors += board.pending_fields.size();
        end

        $display("sent %0d bytes in %0d replies, key matched %0d times",
                 bytes_sent, replies_sent, board.keys_found);
        $display("checked %0d fields: %0d saturated, %0d negative",
                 board.fields_checked, board.overflows_seen, board.negatives_seen);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
